// File: rtl/core/mch_pkg.sv
// package: shared types, constants and the cordic arc table for the heading unit
package mch_pkg;

  localparam int SCALE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int HEADING_BITS_DEF    = 16;
  localparam int MAX_STEPS           = 24;
  localparam int ANG_W               = 32;
  // cordic vector width: 18-bit input scaled by 4096 plus growth and sign
  localparam int CV_W                = 34;
  localparam int STEP_W              = 5;

  typedef enum logic [1:0] {
    CMD_CAL     = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_MEASURE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SAMP  = 2'd1,
    ST_ZERO_RNG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_CORDIC,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic load;
    logic cal_update;
    logic fin_start;
    logic div_step;
    logic fin_commit;
    logic meas_mul;
    logic cordic_step;
    logic out_load;
  } cmd_bus_t;

  typedef struct packed {
    logic    div_done;
    logic    cordic_done;
    cmd_t    cmd;
  } sts_bus_t;

  function automatic logic [ANG_W-1:0] arc_of(input logic [STEP_W-1:0] i);
    logic [ANG_W-1:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/mch_ctrl.sv
// controller state machine sequencing calibration, divide, scale and cordic
module mch_ctrl import mch_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  sts_bus_t sts,
  output logic     busy,
  output logic     out_valid,
  output cmd_bus_t cmd
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // first working cycle: dispatch on command
        case (sts.cmd)
          CMD_CAL: begin
            cmd.cal_update = 1'b1;
            cmd.out_load   = 1'b1;
            state_nxt      = S_OUT;
          end
          CMD_FINISH: begin
            cmd.fin_start = 1'b1;
            state_nxt     = S_DIV;
          end
          CMD_MEASURE: begin
            cmd.meas_mul = 1'b1;
            state_nxt    = S_CORDIC;
          end
          default: begin
            cmd.out_load = 1'b1;
            state_nxt    = S_OUT;
          end
        endcase
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.fin_commit = 1'b1;
          cmd.out_load   = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CORDIC: begin
        if (sts.cordic_done) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.cordic_step = 1'b1;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load)) else $error("result without load");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.div_step && cmd.cordic_step)) else $error("two units stepped");

endmodule

// File: rtl/core/mch_datapath.sv
// datapath: bounds, centers, scale divider, scale multiply and cordic
module mch_datapath import mch_pkg::*; #(
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int HEADING_BITS    = HEADING_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_bus_t           cmd,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_mag_x,
  input  logic signed [15:0] in_mag_y,
  output sts_bus_t           sts,
  output logic [1:0]         o_status,
  output logic signed [17:0] o_comp_x,
  output logic signed [17:0] o_comp_y,
  output logic [15:0]        o_heading
);

  localparam int SC_W   = SCALE_FRAC_BITS + 1;
  localparam int RNG_W  = 17;
  localparam int NUM_W  = RNG_W + SCALE_FRAC_BITS;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int NSTEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int PROD_W = 18 + SC_W + 1;

  logic [1:0]         cmd_r;
  logic signed [15:0] mx_r, my_r;
  logic signed [15:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic               win_r;
  logic signed [16:0] xc_r, yc_r;
  logic [SC_W-1:0]    scale_r;
  logic [1:0]         status_r;
  logic signed [17:0] cx_r, cy_r;
  logic [15:0]        hd_r;

  // divider
  logic [RNG_W-1:0]   dvs_r;
  logic [NUM_W-1:0]   quo_r;
  logic [RNG_W:0]     rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic               zero_r;

  // cordic
  logic signed [CV_W-1:0] vx_r, vy_r;
  logic [ANG_W-1:0]       acc_r;
  logic [STEP_W-1:0]      k_r;
  logic                   zvec_r;

  logic signed [16:0] rx, ry;
  logic signed [17:0] dx, dy;
  logic signed [PROD_W-1:0] prod;
  logic signed [17:0] sx;
  logic [RNG_W:0]     rem_sh;
  logic signed [CV_W-1:0] shx, shy, ix, iy;
  logic [ANG_W-1:0]   rnd;

  assign rx = 17'(x_high_r) - 17'(x_low_r);
  assign ry = 17'(y_high_r) - 17'(y_low_r);
  assign dx = 18'(signed'({mx_r, 1'b0})) - 18'(xc_r);
  assign dy = 18'(signed'({my_r, 1'b0})) - 18'(yc_r);
  assign prod = PROD_W'(dx) * signed'({1'b0, scale_r});
  assign sx = 18'(prod >>> SCALE_FRAC_BITS);
  assign rem_sh = {rem_r[RNG_W-1:0], quo_r[NUM_W-1]};
  assign shx = vx_r >>> k_r;
  assign shy = vy_r >>> k_r;
  assign ix = CV_W'(sx) <<< 12;
  assign iy = CV_W'(dy) <<< 12;
  assign rnd = acc_r + (ANG_W'(1) << (31 - HEADING_BITS));

  assign sts.div_done    = (dcnt_r == '0);
  assign sts.cordic_done = (k_r == STEP_W'(NSTEPS));
  assign sts.cmd         = cmd_t'(cmd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= '0;
      x_high_r <= '0;
      y_low_r  <= '0;
      y_high_r <= '0;
      win_r    <= 1'b0;
      xc_r     <= '0;
      yc_r     <= '0;
      scale_r  <= SC_W'(1) << SCALE_FRAC_BITS;
      dcnt_r   <= '0;
      k_r      <= '0;
    end else begin
      if (cmd.cal_update) begin
        if (!win_r) begin
          x_low_r <= mx_r; x_high_r <= mx_r;
          y_low_r <= my_r; y_high_r <= my_r;
          win_r   <= 1'b1;
        end else begin
          if (mx_r < x_low_r)  x_low_r  <= mx_r;
          if (mx_r > x_high_r) x_high_r <= mx_r;
          if (my_r < y_low_r)  y_low_r  <= my_r;
          if (my_r > y_high_r) y_high_r <= my_r;
        end
      end
      if (cmd.fin_start) begin
        if (win_r && rx != 0 && ry != 0) begin
          dcnt_r <= DCNT_W'(NUM_W);
        end else begin
          dcnt_r <= '0;
        end
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 1'b1;
      end
      if (cmd.fin_commit && win_r) begin
        xc_r  <= 17'(x_low_r) + 17'(x_high_r);
        yc_r  <= 17'(y_low_r) + 17'(y_high_r);
        win_r <= 1'b0;
        if (zero_r) scale_r <= SC_W'(1) << SCALE_FRAC_BITS;
        else        scale_r <= SC_W'(quo_r);
      end
      if (cmd.meas_mul) begin
        k_r <= '0;
      end else if (cmd.cordic_step) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      mx_r  <= in_mag_x;
      my_r  <= in_mag_y;
    end
    if (cmd.fin_start) begin
      zero_r <= (rx == 0) || (ry == 0);
      // numerator is min range shifted, divisor max range
      if (rx <= ry) begin
        quo_r <= NUM_W'(rx) << SCALE_FRAC_BITS;
        dvs_r <= RNG_W'(ry);
      end else begin
        quo_r <= NUM_W'(ry) << SCALE_FRAC_BITS;
        dvs_r <= RNG_W'(rx);
      end
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_sh - {1'b0, dvs_r};
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.meas_mul) begin
      cx_r   <= sx;
      cy_r   <= dy;
      zvec_r <= (sx == 0) && (dy == 0);
      if (sx < 0) begin
        vx_r  <= -ix;
        vy_r  <= -iy;
        acc_r <= 32'h80000000;
      end else begin
        vx_r  <= ix;
        vy_r  <= iy;
        acc_r <= '0;
      end
    end else if (cmd.cordic_step) begin
      if (vy_r > 0) begin
        vx_r  <= vx_r + shy;
        vy_r  <= vy_r - shx;
        acc_r <= acc_r + arc_of(k_r);
      end else begin
        vx_r  <= vx_r - shy;
        vy_r  <= vy_r + shx;
        acc_r <= acc_r - arc_of(k_r);
      end
    end
    if (cmd.out_load) begin
      status_r <= ST_OK;
      o_comp_x <= '0;
      o_comp_y <= '0;
      hd_r     <= '0;
      if (cmd_r == CMD_FINISH) begin
        if (!win_r)       status_r <= ST_NO_SAMP;
        else if (zero_r)  status_r <= ST_ZERO_RNG;
      end
      if (cmd_r == CMD_MEASURE) begin
        o_comp_x <= cx_r;
        o_comp_y <= cy_r;
        hd_r     <= zvec_r ? '0 : 16'(rnd >> (ANG_W - HEADING_BITS));
      end
    end
  end

  assign o_status  = status_r;
  assign o_heading = hd_r;

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    scale_r <= (SC_W'(1) << SCALE_FRAC_BITS)) else $error("scale above one");
  a_win_close: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_commit && win_r |=> !win_r) else $error("window not closed");
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    win_r |-> (x_low_r <= x_high_r) && (y_low_r <= y_high_r)) else $error("bounds crossed");

endmodule

// File: rtl/core/magnetometer_calibration_heading_unit.sv
// top level: magnetometer calibration and heading unit
// usage:
//   input stream carries a command (calibration sample, finish, measure) with
//   a signed x/y magnetometer sample; one result is produced per input.
//   calibration samples update per-axis min/max; finish derives centers and
//   the x scale with a bit-serial restoring divider (33 iterations);
//   measure removes offsets, scales x and runs a serial vectoring cordic,
//   one rotation per cycle (CORDIC_STEPS iterations, capped at 24).
// sequence from input transfer to result valid: calibration / unused code
//   loads the result in the dispatch state; finish runs the divider loop
//   (skipped with no samples or a zero range) and measure the cordic loop
//   before the result register is loaded.
// one item is in flight at a time; in_tready is high only when idle, so the
// next input transfer waits until the result has been taken.
// the result is held in the output register until the receiver takes it,
// and a stalled receiver holds off the next input transfer.
// reset (rst_n low, synchronous) clears bounds, centers, sets scale to one.
module magnetometer_calibration_heading_unit import mch_pkg::*; #(
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int HEADING_BITS    = HEADING_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command[1:0], mag_x[17:2], mag_y[33:18], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // status[1:0], comp_x[19:2], comp_y[37:20],
                                  // heading[53:38], zero pad
);

  cmd_bus_t cmd;
  sts_bus_t sts;
  logic     busy;
  logic [1:0]         st;
  logic signed [17:0] cx, cy;
  logic [15:0]        hd;

  assign in_tready = !busy;

  mch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid && in_tready),
    .out_fire  (out_tvalid && out_tready),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  mch_datapath #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS),
    .HEADING_BITS    (HEADING_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_command (in_tdata[1:0]),
    .in_mag_x   (signed'(in_tdata[17:2])),
    .in_mag_y   (signed'(in_tdata[33:18])),
    .sts        (sts),
    .o_status   (st),
    .o_comp_x   (cx),
    .o_comp_y   (cy),
    .o_heading  (hd)
  );

  assign out_tdata = {2'b00, hd, cy, cx, st};

endmodule

// File: tb/sv/tb.sv
// testbench for the magnetometer calibration and heading unit
module tb;
  import mch_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SFB = 16;
  localparam int STEPS = 16;
  localparam int HBITS = 16;
  localparam longint CYCLE_LIMIT = 1000000;

  // last field in the lowest bits, as on the bus
  typedef struct packed {
    logic [15:0] my;
    logic [15:0] mx;
    cmd_t        cmd;
  } sample_t;

  typedef struct packed {
    logic [15:0] heading;
    logic [17:0] comp_y;
    logic [17:0] comp_x;
    logic [1:0]  status;
  } heading_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;

  magnetometer_calibration_heading_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // calibration state as the block should hold it
  int signed   xl, xh, yl, yh, xc2, yc2;
  bit          win;
  longint      xscale;

  sample_t      pending_q[$];
  heading_res_t expected_q[$];
  int           mismatches = 0;
  bit           failed = 0;
  bit           hold_sender = 0;
  int           long_stall = 0;
  longint       cycles = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] cordic_heading(longint x, longint y);
    logic [31:0] acc;
    longint dx, dy;
    acc = 32'h0;
    if (x == 0 && y == 0) return 16'h0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h80000000;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; acc += arc_of(i[4:0]);
      end else begin
        x -= dx; y += dy; acc -= arc_of(i[4:0]);
      end
    end
    acc += 32'h1 << (31 - HBITS);
    return 16'(acc >> (32 - HBITS));
  endfunction

  function automatic heading_res_t predict_heading(sample_t s);
    heading_res_t r;
    int signed mx, my;
    longint rx, ry, dx, dy, sx;
    r = '0;
    mx = $signed(s.mx);
    my = $signed(s.my);
    case (s.cmd)
      CMD_CAL: begin
        if (!win) begin
          xl = mx; xh = mx; yl = my; yh = my; win = 1;
        end else begin
          if (mx < xl) xl = mx;
          if (mx > xh) xh = mx;
          if (my < yl) yl = my;
          if (my > yh) yh = my;
        end
      end
      CMD_FINISH: begin
        if (!win) r.status = ST_NO_SAMP;
        else begin
          rx = longint'(xh) - xl;
          ry = longint'(yh) - yl;
          xc2 = xl + xh;
          yc2 = yl + yh;
          if (rx == 0 || ry == 0) begin
            xscale = 64'sd1 <<< SFB;
            r.status = ST_ZERO_RNG;
          end else if (rx <= ry) xscale = (rx <<< SFB) / ry;
          else xscale = (ry <<< SFB) / rx;
          win = 0;
        end
      end
      CMD_MEASURE: begin
        dx = 2 * longint'(mx) - xc2;
        dy = 2 * longint'(my) - yc2;
        sx = floor_shr(dx * xscale, SFB);
        r.comp_x = sx[17:0];
        r.comp_y = dy[17:0];
        r.heading = cordic_heading(sx, dy);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic sample_t rand_sample(cmd_t c);
    sample_t s;
    s.cmd = c;
    s.mx = 16'($urandom);
    s.my = 16'($urandom);
    // mostly moderate field strengths, sometimes full scale
    if ($urandom_range(0, 3) != 0) begin
      s.mx = 16'($signed($urandom_range(0, 2000)) - 1000);
      s.my = 16'($signed($urandom_range(0, 2000)) - 1000);
    end
    return s;
  endfunction

  // driver: bursts with random gaps
  int gap = 0;
  int burst = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_heading(sample_t'(in_tdata[33:0])));
      end
      if (in_tvalid && !in_tready) begin
        // keep offering the same item
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_tvalid <= 1'b0;
      end else if (burst <= 0) begin
        burst <= $urandom_range(1, 12);
        gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0 && !hold_sender) begin
        in_tvalid <= 1'b1;
        in_tdata <= {6'b0, pending_q.pop_front()};
        burst <= burst - 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (long_stall > 0) begin
        long_stall <= long_stall - 1;
        out_tready <= 1'b0;
      end else begin
        case (cycles[11:10])
          2'd0: out_tready <= 1'b1;
          2'd1: out_tready <= ($urandom_range(0, 3) != 0);
          2'd2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= cycles[2];
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    heading_res_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = heading_res_t'(out_tdata[53:0]);
      if (expected_q.size() == 0) begin
        failed <= 1;
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transfer %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want || out_tdata[55:54] !== 2'b0) begin
          failed <= 1;
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: status %0d/%0d comp_x %h/%h comp_y %h/%h heading %h/%h",
                     want.status, got.status, want.comp_x, got.comp_x,
                     want.comp_y, got.comp_y, want.heading, got.heading);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("magnetometer_calibration_heading_unit test failed");
      $finish;
    end
  end

  task automatic push(cmd_t c, logic [15:0] x, logic [15:0] y);
    sample_t s;
    s.cmd = c; s.mx = x; s.my = y;
    pending_q.push_back(s);
  endtask

  // sampled at the falling edge, when every clocked update has settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0);
  endtask

  initial begin
    int n, k;
    xl = 0; xh = 0; yl = 0; yh = 0; xc2 = 0; yc2 = 0; win = 0;
    xscale = 64'sd1 <<< SFB;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: finish with no samples, zero vector, extremes, zero range
    push(CMD_FINISH, 16'h0, 16'h0);
    push(CMD_MEASURE, 16'h0, 16'h0);
    push(CMD_MEASURE, 16'h7FFF, 16'h8000);
    push(CMD_MEASURE, 16'h8000, 16'h7FFF);
    push(CMD_NONE, 16'hFFFF, 16'hFFFF);
    push(CMD_CAL, 16'd100, 16'd5);
    push(CMD_CAL, 16'd300, 16'd5);
    push(CMD_FINISH, 16'h0, 16'h0);
    push(CMD_MEASURE, 16'd200, 16'd9);
    push(CMD_CAL, 16'h8000, 16'h8000);
    push(CMD_CAL, 16'h7FFF, 16'h7FFF);
    push(CMD_FINISH, 16'h0, 16'h0);
    push(CMD_MEASURE, 16'h8000, 16'h7FFF);
    push(CMD_MEASURE, 16'h7FFF, 16'h8000);
    push(CMD_CAL, 16'h8000, 16'hFFF0);
    push(CMD_CAL, 16'h7FFF, 16'h0010);
    push(CMD_FINISH, 16'h0, 16'h0);
    push(CMD_MEASURE, 16'h7FFF, 16'h8000);
    push(CMD_MEASURE, 16'h0000, 16'hFFFF);
    push(CMD_FINISH, 16'h0, 16'h0);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    long_stall = 400;
    for (int i = 0; i < 20; i++) pending_q.push_back(rand_sample(CMD_MEASURE));
    wait_drained();

    // random: calibration sessions then measurements, with some noise
    n = 0;
    while (n < 1800) begin
      k = $urandom_range(1, 12);
      for (int i = 0; i < k; i++) pending_q.push_back(rand_sample(CMD_CAL));
      if ($urandom_range(0, 7) == 0)
        pending_q.push_back(rand_sample(cmd_t'($urandom_range(0, 3))));
      pending_q.push_back(rand_sample(CMD_FINISH));
      if ($urandom_range(0, 9) == 0) pending_q.push_back(rand_sample(CMD_FINISH));
      for (int i = 0; i < 15; i++) pending_q.push_back(rand_sample(CMD_MEASURE));
      n += k + 16;
      if ($urandom_range(0, 20) == 0) begin
        hold_sender = 1;
        do @(negedge clk);
        while (expected_q.size() != 0 || in_tvalid);
        hold_sender = 0;
      end
      wait (pending_q.size() < 40);
    end
    wait_drained();
    repeat (100) @(posedge clk);
    if (!failed && expected_q.size() == 0 && pending_q.size() == 0 && !in_tvalid)
      $display("magnetometer_calibration_heading_unit test passed");
    else
      $display("magnetometer_calibration_heading_unit test failed");
    $finish;
  end

endmodule
